/* rtl/index_map_circle_brush_core_defines.svh */
// ----------------------------------------------------------------------------
// Index map circle brush: assertion macros
// Shared check macros; each expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef INDEX_MAP_CIRCLE_BRUSH_CORE_DEFINES_SVH
`define INDEX_MAP_CIRCLE_BRUSH_CORE_DEFINES_SVH

// Check that is suspended while reset is high.
`define IMCB_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also covers the reset cycles.
`define IMCB_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/imcb_pkg.sv */
// ----------------------------------------------------------------------------
// imcb_pkg
// Types, codes and helpers shared by the index map circle brush modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imcb_pkg;

  localparam int MAP_SIDE_MAX_DEF = 256;
  localparam int RADIUS_MAX_DEF   = 64;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] OP_WRITE       = 2'd0;
  localparam logic [1:0] OP_READ        = 2'd1;
  localparam logic [1:0] OP_PAINT_CLIP  = 2'd2;
  localparam logic [1:0] OP_PAINT_WRAP  = 2'd3;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [11:0] x_coord;
    logic signed [11:0] y_coord;
    logic [6:0]         radius;
    logic [16:0]        hardness;
    logic [16:0]        strength;
    logic [7:0]         pixel_value;
  } cmd_t;

  typedef struct packed {
    logic       changed;
    logic [7:0] read_value;
  } result_t;

  // Mask of the largest power of two not above the width, minus one.
  function automatic logic [8:0] wrap_mask(input logic [8:0] w);
    logic [8:0] m;
    m = '0;
    for (int i = 0; i < 9; i++) begin
      if (w[i]) m = 9'((10'd1 << i) - 10'd1);
    end
    return m;
  endfunction

endpackage

/* rtl/imcb_ram.sv */
// ----------------------------------------------------------------------------
// imcb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imcb_ram #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int DW    = 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/imcb_sel.sv */
// ----------------------------------------------------------------------------
// imcb_sel
// Evaluates the brush falloff test for one squared distance: bit-serial square
// root, one or two restoring divisions and one or three registered multiplies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imcb_sel
  import imcb_pkg::*;
#(
  parameter int RBW = 7,
  parameter int TW  = 13
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [TW-1:0]  dist_sq,
  input  logic [RBW-1:0] radius,
  input  logic [16:0]    shoulder,
  input  logic [16:0]    strength,
  output logic           done,
  output logic           hit
);

  localparam int SNW = TW + 32 + (TW % 2);
  localparam int SRW = SNW / 2;
  localparam int IT  = (SRW > 17) ? SRW : 17;
  localparam int CW  = $clog2(IT + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQRT  = 4'd1;
  localparam logic [3:0] S_D1SET = 4'd2;
  localparam logic [3:0] S_DIV1  = 4'd3;
  localparam logic [3:0] S_D2SET = 4'd4;
  localparam logic [3:0] S_DIV2  = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL2  = 4'd7;
  localparam logic [3:0] S_MUL3  = 4'd8;

  logic [3:0]     state;
  logic [CW-1:0]  cnt;
  logic [SNW-1:0] sq_n;
  logic [SRW+1:0] sq_rem;
  logic [SRW-1:0] sq_root;
  logic [16:0]    dv_rem;
  logic [16:0]    dv_low;
  logic [16:0]    dv_q;
  logic [16:0]    dv_div;
  logic [15:0]    u2;
  logic [16:0]    f;

  logic [SRW+1:0] rem_sh;
  logic [SRW+1:0] trial;
  logic [17:0]    dv_sh;
  logic           dv_ge;
  logic [33:0]    n1;

  assign rem_sh = {sq_rem[SRW-1:0], sq_n[SNW-1:SNW-2]};
  assign trial  = {sq_root, 2'b01};
  assign dv_sh  = {dv_rem, dv_low[16]};
  assign dv_ge  = dv_sh >= {1'b0, dv_div};
  assign n1     = 34'({radius, 16'h0000}) - 34'(sq_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            sq_n    <= SNW'(dist_sq) << 32;
            sq_rem  <= '0;
            sq_root <= '0;
            cnt     <= '0;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (rem_sh >= trial) begin
            sq_rem  <= rem_sh - trial;
            sq_root <= {sq_root[SRW-2:0], 1'b1};
          end else begin
            sq_rem  <= rem_sh;
            sq_root <= {sq_root[SRW-2:0], 1'b0};
          end
          sq_n <= sq_n << 2;
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(SRW - 1)) state <= S_D1SET;
        end
        S_D1SET: begin
          // quotient stays below 2^17, so preload the top bits
          dv_rem <= n1[33:17];
          dv_low <= n1[16:0];
          dv_div <= 17'(radius);
          dv_q   <= '0;
          cnt    <= '0;
          state  <= S_DIV1;
        end
        S_DIV1, S_DIV2: begin
          dv_rem <= dv_ge ? 17'(dv_sh - {1'b0, dv_div}) : dv_sh[16:0];
          dv_low <= {dv_low[15:0], 1'b0};
          dv_q   <= {dv_q[15:0], dv_ge};
          cnt    <= cnt + 1'b1;
          if (cnt == CW'(16)) state <= (state == S_DIV1) ? S_D2SET : S_MUL1;
        end
        S_D2SET: begin
          if (shoulder >= 17'd7 && dv_q < shoulder) begin
            dv_rem <= {1'b0, dv_q[16:1]};
            dv_low <= {dv_q[0], 16'h0000};
            dv_div <= shoulder;
            dv_q   <= '0;
            cnt    <= '0;
            state  <= S_DIV2;
          end else begin
            f     <= ONE_Q16;
            state <= S_MUL3;
          end
        end
        S_MUL1: begin
          u2    <= 16'((32'(dv_q[15:0]) * 32'(dv_q[15:0])) >> 16);
          state <= S_MUL2;
        end
        S_MUL2: begin
          f     <= 17'((34'(u2) * 34'(18'd196608 - {1'b0, dv_q[15:0], 1'b0})) >> 16);
          state <= S_MUL3;
        end
        S_MUL3: begin
          hit   <= (34'(f) * 34'(strength)) >= 34'h080000000;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/index_map_circle_brush_core.sv */
// ----------------------------------------------------------------------------
// index_map_circle_brush_core
// 8-bit index map with pixel write/read and clipped or wrapped circle brush.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the transaction is taken at a
//   clock edge where start is high and busy is low. One result per command
//   comes back on result with done high for exactly one cycle; the receiver
//   must take it then, it cannot stall the block.
//   Config port: cfg_we/cfg_index/cfg_data write the map width (index 0) and
//   the map height (index 1) at once; write only while busy is low and no
//   result is due.
//   Sequence: write and read pass through a read and a write state. A paint
//   first fills a selection table, one entry per squared distance 0..r*r,
//   each computed in turn by the falloff unit, then visits (2r+1)^2 brush
//   pixels as read-modify-write on the map memory. A paint that cannot touch
//   the map answers in the cycle after it is accepted.
//   One command is in flight at a time; the next may start in the cycle that
//   shows done.
//   Reset: width and height return to 256, control goes idle. Map contents
//   are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "index_map_circle_brush_core_defines.svh"

module index_map_circle_brush_core
  import imcb_pkg::*;
#(
  parameter int MAP_SIDE_MAX = MAP_SIDE_MAX_DEF,
  parameter int RADIUS_MAX   = RADIUS_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd,
  output logic       done,
  output result_t    result,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int DEPTH  = MAP_SIDE_MAX * MAP_SIDE_MAX;
  localparam int AW     = $clog2(DEPTH);
  localparam int RBW    = $clog2(RADIUS_MAX + 1);
  localparam int TDEPTH = RADIUS_MAX * RADIUS_MAX + 1;
  localparam int TW     = $clog2(TDEPTH);
  localparam int DXW    = RBW + 1;
  localparam int XW     = ((12 > DXW) ? 12 : DXW) + 1;
  localparam int OW     = (AW > 19) ? AW : 19;
  localparam int SQW    = 2 * DXW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BSTART = 3'd1;
  localparam logic [2:0] ST_BWAIT  = 3'd2;
  localparam logic [2:0] ST_RD     = 3'd3;
  localparam logic [2:0] ST_WR     = 3'd4;

  logic [2:0]            state;
  logic [8:0]            width_r;
  logic [8:0]            height_r;
  logic [1:0]            op_r;
  logic signed [11:0]    cx_r;
  logic signed [11:0]    cy_r;
  logic [RBW-1:0]        r_r;
  logic [16:0]           shoulder_r;
  logic [16:0]           str_r;
  logic [7:0]            val_r;
  logic signed [DXW-1:0] dx;
  logic signed [DXW-1:0] dy;
  logic [TW-1:0]         bcnt;
  logic                  changed_r;
  logic                  inside_r;
  logic                  pix_ok_r;
  logic [AW-1:0]         addr_r;

  logic                  accept;
  logic                  exist;
  logic [8:0]            mask;
  logic [RBW-1:0]        r_sat;
  logic [16:0]           hard_sat;
  logic [16:0]           str_sat;
  logic                  single;
  logic [2*RBW-1:0]      rsq;
  logic signed [SQW-1:0] dxe;
  logic signed [SQW-1:0] dye;
  logic [SQW-1:0]        dsq;
  logic                  in_radius;
  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;
  logic [8:0]            xu;
  logic [8:0]            yu;
  logic                  xok;
  logic                  yok;
  logic [OW-1:0]         off;
  logic                  sel_start;
  logic                  sel_done;
  logic                  sel_hit;
  logic                  tbl_we;
  logic                  tbl_q;
  logic                  map_we;
  logic                  pix_diff;
  logic [7:0]            map_q;
  logic                  hit;
  logic                  last;
  logic signed [DXW-1:0] r_s;

  assign accept   = start && !busy;
  assign busy     = state != ST_IDLE;
  assign exist    = (width_r != '0) && (height_r != '0) &&
                    (32'(width_r) * 32'(height_r) <= 32'(DEPTH));
  assign mask     = wrap_mask(width_r);
  assign r_sat    = (int'(cmd.radius) > RADIUS_MAX) ? RBW'(RADIUS_MAX) : RBW'(cmd.radius);
  assign hard_sat = (cmd.hardness > ONE_Q16) ? ONE_Q16 : cmd.hardness;
  assign str_sat  = (cmd.strength > ONE_Q16) ? ONE_Q16 : cmd.strength;
  assign single   = (op_r == OP_WRITE) || (op_r == OP_READ);
  assign rsq      = (2*RBW)'(r_r) * (2*RBW)'(r_r);
  assign r_s      = $signed({1'b0, r_r});

  // brush geometry for the current offset
  assign dxe       = SQW'(dx);
  assign dye       = SQW'(dy);
  assign dsq       = SQW'(dxe * dxe) + SQW'(dye * dye);
  assign in_radius = dsq <= SQW'(rsq);
  assign xs        = XW'(cx_r) + XW'(dx);
  assign ys        = XW'(cy_r) + XW'(dy);

  always_comb begin
    if (op_r == OP_PAINT_WRAP) begin
      xu  = xs[8:0] & mask;
      yu  = ys[8:0] & mask;
      xok = 1'b1;
      yok = yu < height_r;
    end else begin
      xu  = xs[8:0];
      yu  = ys[8:0];
      xok = !xs[XW-1] && (xs[XW-2:0] < (XW-1)'(width_r));
      yok = !ys[XW-1] && (ys[XW-2:0] < (XW-1)'(height_r));
    end
  end

  assign off = OW'(yu) * OW'(width_r) + OW'(xu);

  assign sel_start = state == ST_BSTART;
  assign tbl_we    = (state == ST_BWAIT) && sel_done;
  assign hit       = single || (inside_r && tbl_q);
  // store every selected pixel; the compare only feeds the changed flag
  assign map_we    = (state == ST_WR) && hit && pix_ok_r && (op_r != OP_READ);
  assign pix_diff  = map_we && (map_q != val_r);
  assign last      = single || ((dx == r_s) && (dy == r_s));

  imcb_sel #(
    .RBW (RBW),
    .TW  (TW)
  ) u_sel (
    .clk      (clk),
    .rst      (rst),
    .start    (sel_start),
    .dist_sq  (bcnt),
    .radius   (r_r),
    .shoulder (shoulder_r),
    .strength (str_r),
    .done     (sel_done),
    .hit      (sel_hit)
  );

  imcb_ram #(
    .DEPTH (TDEPTH),
    .AW    (TW),
    .DW    (1)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (bcnt),
    .wdata (sel_hit),
    .raddr (dsq[TW-1:0]),
    .rdata (tbl_q)
  );

  imcb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (8)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (addr_r),
    .wdata (val_r),
    .raddr (off[AW-1:0]),
    .rdata (map_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_MAP_WIDTH) width_r <= cfg_data;
        else                            height_r <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r       <= cmd.op;
            cx_r       <= cmd.x_coord;
            cy_r       <= cmd.y_coord;
            r_r        <= r_sat;
            shoulder_r <= ONE_Q16 - hard_sat;
            str_r      <= str_sat;
            val_r      <= cmd.pixel_value;
            changed_r  <= 1'b0;
            bcnt       <= '0;
            if (cmd.op == OP_WRITE || cmd.op == OP_READ) begin
              dx    <= '0;
              dy    <= '0;
              state <= ST_RD;
            end else if (exist && r_sat != '0 && str_sat != '0) begin
              dx    <= -$signed({1'b0, r_sat});
              dy    <= -$signed({1'b0, r_sat});
              state <= ST_BSTART;
            end else begin
              // nothing to paint: answer at once
              done   <= 1'b1;
              result <= '0;
            end
          end
        end
        ST_BSTART: state <= ST_BWAIT;
        ST_BWAIT: begin
          if (sel_done) begin
            if ((2*RBW+1)'(bcnt) == (2*RBW+1)'(rsq)) begin
              state <= ST_RD;
            end else begin
              bcnt  <= bcnt + 1'b1;
              state <= ST_BSTART;
            end
          end
        end
        ST_RD: begin
          inside_r <= in_radius;
          pix_ok_r <= exist && xok && yok;
          addr_r   <= off[AW-1:0];
          state    <= ST_WR;
        end
        ST_WR: begin
          changed_r <= changed_r | pix_diff;
          if (last) begin
            done              <= 1'b1;
            result.changed    <= changed_r | pix_diff;
            result.read_value <= (op_r == OP_READ && pix_ok_r) ? map_q : 8'h00;
            state             <= ST_IDLE;
          end else begin
            if (dx == r_s) begin
              dx <= -r_s;
              dy <= dy + 1'b1;
            end else begin
              dx <= dx + 1'b1;
            end
            state <= ST_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `IMCB_CHECK(a_done_idle, done |-> !busy, "result strobe while a transaction is in flight")
  `IMCB_CHECK(a_accept_progress, accept |=> (busy || done), "accepted transaction dropped")
  `IMCB_CHECK(a_map_write_phase, map_we |-> (state == ST_WR), "map written outside update")
  `IMCB_CHECK_RST(a_reset_idle, rst |=> (!busy && !done), "block not idle after reset")

endmodule
